[design/rc4_stream_cipher_with_drop_core_assert.svh]
// Assertion macros for the RC4-drop core.
`ifndef RC4_STREAM_CIPHER_WITH_DROP_CORE_ASSERT_SVH
`define RC4_STREAM_CIPHER_WITH_DROP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define RC4D_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4d assertion failed");
// Next-cycle implication, checked out of reset.
`define RC4D_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4d assertion failed");
`else
`define RC4D_ASSERT_IMP(name, ante, cons)
`define RC4D_ASSERT_NXT(name, ante, cons)
`endif
`endif

[design/rc4d_pkg.sv]
package rc4d_pkg;

    localparam int BYTE_W    = 8;
    localparam int KEY_BYTES = 16;
    localparam int KEY_IDX_W = 4;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    typedef logic [BYTE_W-1:0] byte_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

    localparam logic [LEN_W-1:0] KEY_LENGTH_RST = 5'd16;

    // action codes
    localparam logic ACT_REKEY = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // one memory access per cycle: a write and/or a read
    typedef struct packed {
        logic  wr_en;
        byte_t wr_addr;
        byte_t wr_data;
        logic  rd_en;
        byte_t rd_addr;
    } mem_req_t;

endpackage

[design/rc4d_mem.sv]
module rc4d_mem
    import rc4d_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output byte_t    rd_data
);

    byte_t mem [256];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        // read data holds between reads
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rc4_stream_cipher_with_drop_core.sv]
// RC4-drop stream cipher core, permutation held in one 256x8 synchronous RAM.
// Data beat: accepted in idle; G_RD_I, G_RD_J, G_WR_I, result registered in G_WR_J, which stalls
// while the output is full; the next beat waits for idle. Rekey beat: RAM fill, key schedule,
// then dropped bytes; no result. Every step is bounded by the single RAM read and write port.
// Reset (async, active low) clears i, j, control and key, sets length 16; RAM is not cleared.
// A result waiting in the output register does not block the next input beat.
`include "rc4_stream_cipher_with_drop_core_assert.svh"
module rc4_stream_cipher_with_drop_core
    import rc4d_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [7:0]           data_byte,
    input  logic [7:0]           discard_count,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           result_byte,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_G_RD_I,
        ST_G_RD_J,
        ST_G_WR_I,
        ST_G_WR_J
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   key_low_reg;
    logic [CFG_W-1:0]   key_high_reg;
    logic [LEN_W-1:0]   key_length_reg;

    byte_t              n_reg;
    byte_t              i_reg;
    byte_t              j_reg;
    byte_t              si_reg;
    byte_t              drop_reg;
    logic               drop_mode_reg;
    byte_t              data_reg;
    logic               fwd_hit_reg;
    byte_t              fwd_val_reg;
    logic [KPOS_W-1:0]  kpos_reg;
    logic               out_valid_reg;
    byte_t              result_reg;

    mem_req_t           mem_req;
    byte_t              rd_data;

    byte_t              key_arr [KEY_BYTES];
    logic [KEY_IDX_W-1:0] kidx;
    byte_t              key_byte;
    logic [LEN_W-1:0]   eff_len;
    logic               kpos_wrap;
    byte_t              ks_j_next;
    byte_t              g_j_next;
    byte_t              ks_addr;
    byte_t              keystream;
    logic               out_free;
    logic               result_load;

    rc4d_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // key bytes 0..15 from the two key words
    always_comb
    begin
        for (int k = 0; k < KEY_BYTES / 2; k++)
        begin
            key_arr[k]                 = key_low_reg[k*BYTE_W +: BYTE_W];
            key_arr[k + KEY_BYTES / 2] = key_high_reg[k*BYTE_W +: BYTE_W];
        end
    end

    assign kidx     = KEY_IDX_W'(kpos_reg);
    assign key_byte = key_arr[kidx];

    // zero length acts as one, long lengths clamp
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (key_length_reg > LEN_W'(MAX_KEY_BYTES))
        begin
            eff_len = LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = key_length_reg;
        end
    end

    assign kpos_wrap = (LEN_W'(kpos_reg) + LEN_W'(1)) == eff_len;
    assign ks_j_next = j_reg + rd_data + key_byte;
    assign g_j_next  = j_reg + rd_data;
    assign ks_addr   = si_reg + rd_data;
    assign keystream = fwd_hit_reg ? fwd_val_reg : rd_data;
    assign out_free  = !out_valid_reg || out_ready;
    // a data beat loads the output register this cycle
    assign result_load = (state_reg == ST_G_WR_J) && !drop_mode_reg && out_free;

    always_comb
    begin
        mem_req = '0;
        case (state_reg)
            ST_INIT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg;
                mem_req.wr_data = n_reg;
            end
            ST_KS_RD_I:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = n_reg;
            end
            ST_KS_RD_J:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ks_j_next;
            end
            ST_KS_WR_I:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg;
                mem_req.wr_data = rd_data;
            end
            ST_KS_WR_J, ST_G_WR_J:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg;
                mem_req.wr_data = si_reg;
            end
            ST_G_RD_I:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = i_reg + 8'd1;
            end
            ST_G_RD_J:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = g_j_next;
            end
            ST_G_WR_I:
            begin
                // swap write of S[i] and keystream read share this cycle
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = i_reg;
                mem_req.wr_data = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ks_addr;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            kpos_reg      <= '0;
            drop_reg      <= '0;
            drop_mode_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !result_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        data_reg <= data_byte;
                        if (action == ACT_REKEY)
                        begin
                            drop_reg  <= discard_count;
                            n_reg     <= '0;
                            state_reg <= ST_INIT;
                        end
                        else
                        begin
                            drop_mode_reg <= 1'b0;
                            state_reg     <= ST_G_RD_I;
                        end
                    end
                end
                ST_INIT:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == 8'hFF)
                    begin
                        j_reg     <= '0;
                        kpos_reg  <= '0;
                        state_reg <= ST_KS_RD_I;
                    end
                end
                ST_KS_RD_I:
                begin
                    state_reg <= ST_KS_RD_J;
                end
                ST_KS_RD_J:
                begin
                    si_reg    <= rd_data;
                    j_reg     <= ks_j_next;
                    state_reg <= ST_KS_WR_I;
                end
                ST_KS_WR_I:
                begin
                    state_reg <= ST_KS_WR_J;
                end
                ST_KS_WR_J:
                begin
                    n_reg    <= n_reg + 8'd1;
                    kpos_reg <= kpos_wrap ? '0 : kpos_reg + KPOS_W'(1);
                    if (n_reg == 8'hFF)
                    begin
                        i_reg         <= '0;
                        j_reg         <= '0;
                        drop_mode_reg <= 1'b1;
                        state_reg     <= (drop_reg == '0) ? ST_IDLE : ST_G_RD_I;
                    end
                    else
                    begin
                        state_reg <= ST_KS_RD_I;
                    end
                end
                ST_G_RD_I:
                begin
                    i_reg     <= i_reg + 8'd1;
                    state_reg <= ST_G_RD_J;
                end
                ST_G_RD_J:
                begin
                    si_reg    <= rd_data;
                    j_reg     <= g_j_next;
                    state_reg <= ST_G_WR_I;
                end
                ST_G_WR_I:
                begin
                    // keystream read sees pre-swap RAM: forward the swapped values
                    if (ks_addr == i_reg)
                    begin
                        fwd_hit_reg <= 1'b1;
                        fwd_val_reg <= rd_data;
                    end
                    else if (ks_addr == j_reg)
                    begin
                        fwd_hit_reg <= 1'b1;
                        fwd_val_reg <= si_reg;
                    end
                    else
                    begin
                        fwd_hit_reg <= 1'b0;
                    end
                    state_reg <= ST_G_WR_J;
                end
                ST_G_WR_J:
                begin
                    if (drop_mode_reg)
                    begin
                        drop_reg  <= drop_reg - 8'd1;
                        state_reg <= (drop_reg == 8'd1) ? ST_IDLE : ST_G_RD_I;
                    end
                    else if (out_free)
                    begin
                        result_reg    <= data_reg ^ keystream;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `RC4D_ASSERT_NXT(a_rekey_starts_fill, in_valid && in_ready && action == ACT_REKEY,
                     state_reg == ST_INIT && n_reg == '0)
    `RC4D_ASSERT_NXT(a_no_result_in_schedule, state_reg == ST_INIT && !out_valid_reg,
                     !out_valid_reg)
    `RC4D_ASSERT_IMP(a_drop_never_zero, state_reg == ST_G_WR_J && drop_mode_reg, drop_reg != '0)

endmodule

[verif/rc4_stream_cipher_with_drop_core_tb.sv]
module rc4_stream_cipher_with_drop_core_tb
    import rc4d_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 2_000_000;
    // worst rekey: fill, full key schedule and 255 dropped bytes
    localparam int SETTLE_CYCLES = 2400;
    localparam int HOLD_CYCLES   = 400;
    localparam int TARGET_ITEMS  = 1200;

    // Keystream predictor plus the queue of ciphertext bytes still owed by the core.
    class rc4_scoreboard;
        byte_t            perm [256];
        byte_t            idx_i;
        byte_t            idx_j;
        logic [CFG_W-1:0] key_lo;
        logic [CFG_W-1:0] key_hi;
        logic [LEN_W-1:0] key_len;
        byte_t            expected_q [$];
        int               errors;

        function new();
            key_lo  = '0;
            key_hi  = '0;
            key_len = KEY_LENGTH_RST;
            foreach (perm[n])
                perm[n] = '0;
            idx_i  = '0;
            idx_j  = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_KEY_LOW:    key_lo = val;
                CFG_KEY_HIGH:   key_hi = val;
                CFG_KEY_LENGTH: key_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function byte_t keystream();
            byte_t t;
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            return perm[byte_t'(perm[idx_i] + perm[idx_j])];
        endfunction

        function void note_input(logic act, byte_t d, byte_t dc);
            int    len;
            int    k;
            int    n;
            byte_t j;
            byte_t t;
            byte_t kb;
            if (act == ACT_REKEY)
            begin
                // zero length acts as one, anything above the key size saturates
                len = int'(key_len);
                if (len < 1)
                    len = 1;
                if (len > KEY_BYTES)
                    len = KEY_BYTES;
                for (n = 0; n < 256; n++)
                    perm[n] = byte_t'(n);
                j = '0;
                for (n = 0; n < 256; n++)
                begin
                    k  = n % len;
                    kb = (k < 8) ? key_lo[8*k +: 8] : key_hi[8*(k-8) +: 8];
                    j  = j + perm[n] + kb;
                    t       = perm[n];
                    perm[n] = perm[j];
                    perm[j] = t;
                end
                idx_i = '0;
                idx_j = '0;
                repeat (dc)
                    void'(keystream());
            end
            else
                expected_q.insert(expected_q.size(), d ^ keystream());
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(byte_t got);
            byte_t want;
            if (expected_q.size() == 0)
                report($sformatf("result 0x%02h with nothing pending", got));
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                    report($sformatf("result_byte 0x%02h, want 0x%02h", got, want));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [7:0]           data_byte;
    logic [7:0]           discard_count;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           result_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rc4_scoreboard sb;
    bit            steady;
    bit            hold_req;
    int            items_sent;

    rc4_stream_cipher_with_drop_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .discard_count (discard_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_byte   (result_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic byte_t pick_discard();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return byte_t'($urandom_range(0, 3));
        if (r < 80)
            return byte_t'($urandom);
        return (r < 90) ? 8'hFF : 8'h00;
    endfunction

    task automatic send_beat(logic act, byte_t d, byte_t dc);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        action        = act;
        data_byte     = d;
        discard_count = dc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(act, d, dc);
        items_sent++;
    endtask

    task automatic send_rekey(byte_t dc);
        send_beat(ACT_REKEY, byte_t'($urandom), dc);
    endtask

    task automatic send_byte(byte_t d);
        send_beat(ACT_DATA, d, byte_t'($urandom));
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_key(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, logic [LEN_W-1:0] len);
        logic [CFG_W-1:0] v;
        // junk in the upper bits of the length write must be ignored
        v = {$urandom, $urandom};
        v[LEN_W-1:0] = len;
        write_cfg(CFG_KEY_LOW, lo);
        write_cfg(CFG_KEY_HIGH, hi);
        write_cfg(CFG_KEY_LENGTH, v);
    endtask

    // Drop valid, drain owed bytes, then give a trailing rekey time to finish.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0 && waited < SETTLE_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_q.size() != 0)
        begin
            sb.report($sformatf("%0d result beats never arrived", sb.expected_q.size()));
            sb.expected_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_byte);
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin : sink
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                if (!steady && $urandom_range(0, 9) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int               phase;
        int               runs;
        int               burst;
        bit               hold;
        logic [LEN_W-1:0] len;
        sb            = new();
        steady        = 1'b0;
        hold_req      = 1'b0;
        items_sent    = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_REKEY;
        data_byte     = '0;
        discard_count = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_KEY_LOW;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key (all zero, 16 bytes), no drop, max drop, back-to-back rekeys
        send_rekey(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_rekey(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_rekey(8'h01);
        send_rekey(8'h00);
        send_byte(8'h3C);
        send_byte(8'hC3);
        settle();
        set_key('1, '1, 5'd1);
        send_rekey(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        settle();
        // zero length behaves as one byte
        set_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd0);
        send_rekey(8'h02);
        send_byte(8'h11);
        settle();
        // lengths above 16 saturate
        set_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd31);
        send_rekey(8'h00);
        send_byte(8'h22);
        settle();
        set_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd17);
        send_rekey(8'd200);
        send_byte(8'h33);
        settle();
        set_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd16);
        send_rekey(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        settle();

        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 4))
                    0:       len = 5'd0;
                    1:       len = 5'd31;
                    2:       len = 5'd1;
                    3:       len = LEN_W'($urandom_range(17, 31));
                    default: len = 5'd16;
                endcase
            end
            else
                len = LEN_W'($urandom_range(1, 16));
            set_key({$urandom, $urandom}, {$urandom, $urandom}, len);
            // mostly rekey first; otherwise the old stream keeps running
            if ($urandom_range(0, 4) != 0)
                send_rekey(pick_discard());
            runs = $urandom_range(1, 4);
            for (int r = 0; r < runs; r++)
            begin
                hold  = (phase == 2 && r == 0);
                burst = hold ? 60 : $urandom_range(1, 50);
                for (int b = 0; b < burst; b++)
                begin
                    send_byte(byte_t'($urandom));
                    if (hold && b == 0)
                        hold_req = 1'b1;
                end
                if (r < runs - 1 && $urandom_range(0, 2) != 0)
                begin
                    send_rekey(pick_discard());
                    if ($urandom_range(0, 5) == 0)
                        send_rekey(pick_discard());
                end
            end
            settle();
            phase++;
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
